// ===== hw/rtl/vacc_pkg.sv =====
// Shared constants and controller/datapath interface types for the
// vector acceleration limiter. No dependencies.
package vacc_pkg;

    localparam int SPEED_WIDTH_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int LIM_W           = 16;
    localparam logic [LIM_W-1:0] LIM_RESET = 16'hFFFF;

    typedef struct packed {
        logic load;
        logic sq_x;
        logic sq_y;
        logic sum;
        logic root_step;
        logic cmp;
        logic mul_x;
        logic div_init_x;
        logic div_init_y;
        logic div_step;
        logic finish;
    } vacc_cmd_t;

    typedef struct packed {
        logic over;
    } vacc_sts_t;

endpackage

// ===== hw/rtl/vector_acceleration_limiter.sv =====
// Top level of the vector acceleration limiter: controller plus datapath.
// Depends on vacc_pkg, vacc_ctrl and vacc_dp.
//
// Input channel: in_valid / in_stall carry one velocity request
// (target_x, target_y). Output channel: out_valid / out_stall carry the
// limited velocity (out_x, out_y), one result per request.
// Config channel: cfg_valid / cfg_ready write max_step; cfg_ready is always
// high. Write it only while the block is idle.
// When the step is within the limit the divisions are skipped. The input
// frees as out_valid rises. The bit-serial square root and the two
// bit-serial divisions produce one result bit per cycle. One request is
// in flight at a time, plus one finished result held in the output
// register. A new request is taken while a finished result waits.
// If the receiver stalls, the next result waits in its final state until
// the output register frees, and the input stays stalled meanwhile.
// Reset clears the last output velocity to zero, sets max_step to 65535
// and drops any pending result.
module vector_acceleration_limiter #(
    parameter int SPEED_WIDTH = vacc_pkg::SPEED_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [vacc_pkg::FIELD_W-1:0]  target_x,
    input  logic [vacc_pkg::FIELD_W-1:0]  target_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [vacc_pkg::FIELD_W-1:0]  out_x,
    output logic [vacc_pkg::FIELD_W-1:0]  out_y,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vacc_pkg::LIM_W-1:0]    cfg_data
);

    vacc_pkg::vacc_cmd_t cmd;
    vacc_pkg::vacc_sts_t sts;

    assign cfg_ready = 1'b1;

    vacc_ctrl #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    vacc_dp #(
        .SPEED_WIDTH (SPEED_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .target_x (target_x),
        .target_y (target_y),
        .out_x    (out_x),
        .out_y    (out_y)
    );

endmodule

// ===== hw/rtl/vacc_dp.sv =====
// Datapath of the vector acceleration limiter: step, shared multiplier,
// bit-serial square root and divider, last-output and limit registers.
// Depends on vacc_pkg.
module vacc_dp #(
    parameter int SPEED_WIDTH = vacc_pkg::SPEED_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vacc_pkg::vacc_cmd_t           cmd,
    output vacc_pkg::vacc_sts_t           sts,
    input  logic                          cfg_we,
    input  logic [vacc_pkg::LIM_W-1:0]    cfg_data,
    input  logic [vacc_pkg::FIELD_W-1:0]  target_x,
    input  logic [vacc_pkg::FIELD_W-1:0]  target_y,
    output logic [vacc_pkg::FIELD_W-1:0]  out_x,
    output logic [vacc_pkg::FIELD_W-1:0]  out_y
);

    localparam int W   = SPEED_WIDTH;
    localparam int K   = W + 1;
    localparam int BW  = (K > vacc_pkg::LIM_W) ? K : vacc_pkg::LIM_W;
    localparam int PW  = K + BW;
    localparam int RW  = 2 * W + 2;
    localparam int SRW = W + 3;

    logic signed [W-1:0]        tx_reg, ty_reg, prev_x_reg, prev_y_reg;
    logic [K-1:0]               ax_reg, ay_reg;
    logic                       sx_reg, sy_reg;
    logic [PW-1:0]              prod_reg;
    logic [RW-1:0]              rad_reg;
    logic [SRW-1:0]             rem_reg;
    logic [K-1:0]               root_reg;
    logic                       over_reg;
    logic [W:0]                 drem_reg;
    logic [K-1:0]               dq_reg, qx_reg;
    logic [vacc_pkg::LIM_W-1:0] lim_reg;
    logic [vacc_pkg::FIELD_W-1:0] out_x_reg, out_y_reg;

    logic [31:0]         in_x32, in_y32;
    logic signed [W-1:0] tx_in, ty_in;
    logic [W:0]          dx_in, dy_in;
    logic [BW-1:0]       mul_a, mul_b;
    logic [2*BW-1:0]     mul_full;
    logic [SRW+1:0]      rem_sh, trial;
    logic [W+1:0]        dsh, mag_ext;
    logic                dge;
    logic signed [W+1:0] step_x, step_y, ox_full, oy_full;
    logic signed [W-1:0] ox_w, oy_w;
    logic signed [31:0]  ox32, oy32;

    assign in_x32 = {16'b0, target_x};
    assign in_y32 = {16'b0, target_y};
    assign tx_in  = signed'(in_x32[W-1:0]);
    assign ty_in  = signed'(in_y32[W-1:0]);
    assign dx_in  = {tx_in[W-1], tx_in} - {prev_x_reg[W-1], prev_x_reg};
    assign dy_in  = {ty_in[W-1], ty_in} - {prev_y_reg[W-1], prev_y_reg};

    always_comb
    begin
        mul_a = BW'(ax_reg);
        mul_b = BW'(ax_reg);
        if (cmd.sq_y)
        begin
            mul_a = BW'(ay_reg);
            mul_b = BW'(ay_reg);
        end
        else if (cmd.mul_x)
        begin
            mul_b = BW'(lim_reg);
        end
        else if (cmd.div_init_x)
        begin
            mul_a = BW'(ay_reg);
            mul_b = BW'(lim_reg);
        end
    end
    assign mul_full = mul_a * mul_b;

    assign rem_sh  = {rem_reg, rad_reg[RW-1:RW-2]};
    assign trial   = (SRW+2)'({root_reg, 2'b01});
    assign dsh     = {drem_reg, dq_reg[K-1]};
    assign mag_ext = (W+2)'(root_reg);
    assign dge     = (dsh >= mag_ext);

    assign sts.over = (BW'(root_reg) > BW'(lim_reg));

    assign step_x  = sx_reg ? -signed'({1'b0, qx_reg}) : signed'({1'b0, qx_reg});
    assign step_y  = sy_reg ? -signed'({1'b0, dq_reg}) : signed'({1'b0, dq_reg});
    assign ox_full = (W+2)'(prev_x_reg) + step_x;
    assign oy_full = (W+2)'(prev_y_reg) + step_y;
    assign ox_w    = over_reg ? ox_full[W-1:0] : tx_reg;
    assign oy_w    = over_reg ? oy_full[W-1:0] : ty_reg;
    assign ox32    = 32'(ox_w);
    assign oy32    = 32'(oy_w);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg    <= vacc_pkg::LIM_RESET;
            prev_x_reg <= '0;
            prev_y_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                lim_reg <= cfg_data;
            if (cmd.finish)
            begin
                prev_x_reg <= ox_w;
                prev_y_reg <= oy_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tx_reg <= tx_in;
            ty_reg <= ty_in;
            sx_reg <= dx_in[W];
            sy_reg <= dy_in[W];
            ax_reg <= dx_in[W] ? K'(-dx_in) : K'(dx_in);
            ay_reg <= dy_in[W] ? K'(-dy_in) : K'(dy_in);
        end
        if (cmd.sq_x || cmd.sq_y || cmd.mul_x || cmd.div_init_x)
            prod_reg <= mul_full[PW-1:0];
        if (cmd.sq_y)
            rad_reg <= prod_reg[RW-1:0];
        if (cmd.sum)
        begin
            rad_reg  <= rad_reg + prod_reg[RW-1:0];
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg <= rad_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= SRW'(rem_sh - trial);
                root_reg <= {root_reg[K-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= SRW'(rem_sh);
                root_reg <= {root_reg[K-2:0], 1'b0};
            end
        end
        if (cmd.cmp)
            over_reg <= sts.over;
        if (cmd.div_init_x || cmd.div_init_y)
        begin
            drem_reg <= (W+1)'(prod_reg >> K);
            dq_reg   <= prod_reg[K-1:0];
        end
        if (cmd.div_init_y)
            qx_reg <= dq_reg;
        if (cmd.div_step)
        begin
            drem_reg <= dge ? (W+1)'(dsh - mag_ext) : (W+1)'(dsh);
            dq_reg   <= {dq_reg[K-2:0], dge};
        end
        if (cmd.finish)
        begin
            out_x_reg <= ox32[vacc_pkg::FIELD_W-1:0];
            out_y_reg <= oy32[vacc_pkg::FIELD_W-1:0];
        end
    end

    assign out_x = out_x_reg;
    assign out_y = out_y_reg;

endmodule

// ===== hw/rtl/vacc_ctrl.sv =====
// Controller of the vector acceleration limiter: sequences the datapath
// and owns the input and output handshakes. Depends on vacc_pkg.
module vacc_ctrl #(
    parameter int SPEED_WIDTH = vacc_pkg::SPEED_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output vacc_pkg::vacc_cmd_t cmd,
    input  vacc_pkg::vacc_sts_t sts
);

    localparam int K  = SPEED_WIDTH + 1;
    localparam int CW = $clog2(K);
    localparam logic [CW-1:0] CNT_LAST = CW'(K - 1);

    typedef enum logic [3:0] {
        IDLE, SQX, SQY, SUM, ROOT, CMP, MULX, DINX, DIVX, DINY, DIVY, FIN
    } state_t;

    state_t        state_reg;
    logic [CW-1:0] cnt_reg;
    logic          out_valid_reg;
    logic          out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            IDLE: cmd.load       = in_valid;
            SQX:  cmd.sq_x       = 1'b1;
            SQY:  cmd.sq_y       = 1'b1;
            SUM:  cmd.sum        = 1'b1;
            ROOT: cmd.root_step  = 1'b1;
            CMP:  cmd.cmp        = 1'b1;
            MULX: cmd.mul_x      = 1'b1;
            DINX: cmd.div_init_x = 1'b1;
            DIVX: cmd.div_step   = 1'b1;
            DINY: cmd.div_init_y = 1'b1;
            DIVY: cmd.div_step   = 1'b1;
            FIN:  cmd.finish     = out_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE: if (in_valid) state_reg <= SQX;
                SQX:  state_reg <= SQY;
                SQY:  state_reg <= SUM;
                SUM:
                begin
                    state_reg <= ROOT;
                    cnt_reg   <= CNT_LAST;
                end
                ROOT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= CMP;
                end
                CMP:  state_reg <= sts.over ? MULX : FIN;
                MULX: state_reg <= DINX;
                DINX:
                begin
                    state_reg <= DIVX;
                    cnt_reg   <= CNT_LAST;
                end
                DIVX:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= DINY;
                end
                DINY:
                begin
                    state_reg <= DIVY;
                    cnt_reg   <= CNT_LAST;
                end
                DIVY:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= FIN;
                end
                FIN:  if (out_free) state_reg <= IDLE;
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule

// ===== hw/rtl/vacc_check.sv =====
// Port-level checks for the vector acceleration limiter, bound to the top.
// Depends on vacc_pkg and vector_acceleration_limiter.
module vacc_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [vacc_pkg::FIELD_W-1:0]  out_x,
    input logic [vacc_pkg::FIELD_W-1:0]  out_y,
    input logic                          cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y))
        else $error("stalled result changed or dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall && !$rose(out_valid))
        else $error("request accepted without entering compute");

    a_done_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("input still stalled after result delivered");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind vector_acceleration_limiter vacc_check u_vacc_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y),
    .cfg_ready (cfg_ready)
);
